FILE: hw/rtl/rbps_pkg.sv
// Shared types, constants and helper functions of the red-black Poisson smoother.
`timescale 1ns / 1ps

package rbps_pkg;

	// Data and accumulator widths.
	localparam int DATA_W = 32;
	localparam int ACC_W  = 56;

	// Default grid side limit handed to the top level.
	localparam int DEF_MAX_SIDE = 64;

	// Register reset values.
	localparam logic [6:0]  RST_GRID_WIDTH  = 7'd64;
	localparam logic [6:0]  RST_GRID_HEIGHT = 7'd64;
	localparam logic [7:0]  RST_SWEEP_COUNT = 8'd2;
	localparam logic [31:0] RST_INV_DX2     = 32'd65536;
	localparam logic [31:0] RST_INV_DY2     = 32'd65536;
	localparam logic [31:0] RST_INV_DEN     = 32'd1073741824;

	// Configuration register indexes.
	localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_SWEEP_COUNT = 3'd2;
	localparam logic [2:0] CFG_INV_DX2     = 3'd3;
	localparam logic [2:0] CFG_INV_DY2     = 3'd4;
	localparam logic [2:0] CFG_INV_DEN     = 3'd5;

	// Item kinds.
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_RUN   = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Last operand index of a relaxation and of a residual.
	localparam logic [2:0] LAST_RELAX_OP = 3'd3;
	localparam logic [2:0] LAST_RESID_OP = 3'd5;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDO,
		ST_CELL,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_SC0,
		ST_SC1,
		ST_SC2,
		ST_SC3,
		ST_SC4,
		ST_WR,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		DIR_E,
		DIR_W,
		DIR_N,
		DIR_S,
		DIR_P
	} dir_t;

	typedef struct packed {
		dir_t dir;
		logic use_cy;
		logic neg;
		logic dbl;
	} op_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_16,
		SH_32
	} mul_shift_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		mul_shift_t  sh;
	} mul_req_t;

	// Operand list of one cell: four neighbors, then the center twice for a residual.
	function automatic op_t op_desc(input logic relax, input logic [2:0] idx);
		op_t d;
		case (idx)
			3'd0: begin
				d.dir = DIR_E;
			end
			3'd1: begin
				d.dir = DIR_W;
			end
			3'd2: begin
				d.dir = DIR_N;
			end
			3'd3: begin
				d.dir = DIR_S;
			end
			default: begin
				d.dir = DIR_P;
			end
		endcase
		d.use_cy = (idx == 3'd2) || (idx == 3'd3) || (idx == 3'd5);
		d.neg    = !relax && (idx < 3'd4);
		d.dbl    = (idx >= 3'd4);
		return d;
	endfunction

	// Clamp an accumulator value to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic [ACC_W-1:0] v);
		logic [31:0] r;
		if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
			r = v[31:0];
		end else if (v[ACC_W-1]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7fff_ffff;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/red_black_poisson_smoother_unit.sv
// Top level of the red-black Gauss-Seidel Poisson smoother.
`timescale 1ns / 1ps
//
// Items enter on in_valid/in_ready (kind, row, col, phi_value, rhs_value) and each
// gives one result on out_valid/out_ready (phi_out, residual_out, status).
// Registers are written through cfg_write/cfg_index/cfg_data; the user must do so
// only while the block is idle, as the block does not enforce it. A write item,
// an out-of-grid read and an unused kind finish at the transfer; the result is
// registered and shows in the cycle after it. An in-grid read first goes through
// the registered memory read and the ST_RDO state.
// A run item holds in_ready low until every sweep and the residual of every
// interior cell are done. The single shared multiplier paces this: every neighbor
// product and both halves of the final scaling go through it one at a time, each
// operand passing through the ST_RD, ST_MUL and ST_ACC states.
// A new item is taken only when the output register is empty or being emptied,
// so a stalled receiver holds the block with its result intact.
// After reset the residual memory is cleared, one entry a cycle, over all
// 2^(2*ceil(log2(MAX_SIDE))) entries (4096 at the default); no item is accepted
// meanwhile, while register writes are taken.

module red_black_poisson_smoother_unit #(
	parameter int MAX_SIDE = rbps_pkg::DEF_MAX_SIDE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	input  logic [31:0] phi_value,
	input  logic [31:0] rhs_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] phi_out,
	output logic [31:0] residual_out,
	output logic        status,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SW  = $clog2(MAX_SIDE);
	localparam int AW  = 2 * SW;
	localparam int CW0 = $clog2(MAX_SIDE + 3);
	localparam int CW  = ((CW0 > 7) ? CW0 : 7) + 1;
	localparam int ACC_W = rbps_pkg::ACC_W;

	// Configuration registers.
	logic [6:0]  grid_w_q;
	logic [6:0]  grid_h_q;
	logic [7:0]  sweep_q;
	logic [31:0] cx_q;
	logic [31:0] cy_q;
	logic [31:0] den_q;

	rbps_pkg::state_t st_q;
	rbps_pkg::state_t st_d;

	logic [7:0]    it_q;
	logic          color_q;
	logic          relax_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [2:0]    op_q;
	logic [AW-1:0] clr_q;

	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] nmag_q;
	logic             nneg_q;
	logic             sgn_q;

	logic [CW-1:0] eff_w;
	logic [CW-1:0] eff_h;
	logic          in_grid;
	logic          accept;
	logic [AW-1:0] item_addr;
	logic [AW-1:0] cell_addr;
	logic [SW-1:0] ia;
	logic [SW-1:0] ja;

	rbps_pkg::op_t    cur_op;
	rbps_pkg::mul_req_t mul_req;
	logic [63:0]      prod_s1;
	logic [ACC_W-1:0] term;
	logic [ACC_W-1:0] final_val;
	logic [2:0]       last_op;

	logic [CW-1:0] step;
	logic [CW-1:0] jn;
	logic          cell_ok;
	logic          col_more;
	logic          row_more;
	logic [CW-1:0] row_start;

	// Memories and their ports.
	logic [31:0] phi_mem [0:(2**AW)-1];
	logic [31:0] rhs_mem [0:(2**AW)-1];
	logic [31:0] res_mem [0:(2**AW)-1];
	logic [31:0] phi_rd_q;
	logic [31:0] rhs_rd_q;
	logic [31:0] res_rd_q;
	logic [AW-1:0] phi_raddr;
	logic          phi_we;
	logic [AW-1:0] phi_waddr;
	logic [31:0]   phi_wdata;
	logic          rhs_we;
	logic          res_we;
	logic [AW-1:0] res_waddr;
	logic [31:0]   res_wdata;

	logic        out_valid_q;
	logic [31:0] phi_out_q;
	logic [31:0] res_out_q;
	logic        status_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= rbps_pkg::RST_GRID_WIDTH;
			grid_h_q <= rbps_pkg::RST_GRID_HEIGHT;
			sweep_q  <= rbps_pkg::RST_SWEEP_COUNT;
			cx_q     <= rbps_pkg::RST_INV_DX2;
			cy_q     <= rbps_pkg::RST_INV_DY2;
			den_q    <= rbps_pkg::RST_INV_DEN;
		end else if (cfg_write) begin
			case (cfg_index)
				rbps_pkg::CFG_GRID_WIDTH: begin
					grid_w_q <= cfg_data[6:0];
				end
				rbps_pkg::CFG_GRID_HEIGHT: begin
					grid_h_q <= cfg_data[6:0];
				end
				rbps_pkg::CFG_SWEEP_COUNT: begin
					sweep_q <= cfg_data[7:0];
				end
				rbps_pkg::CFG_INV_DX2: begin
					cx_q <= cfg_data;
				end
				rbps_pkg::CFG_INV_DY2: begin
					cy_q <= cfg_data;
				end
				rbps_pkg::CFG_INV_DEN: begin
					den_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Effective grid size, item addressing and loop conditions.
	always_comb begin
		eff_w = (grid_w_q < 7'd3) ? CW'(3) :
			((CW'(grid_w_q) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(grid_w_q));
		eff_h = (grid_h_q < 7'd3) ? CW'(3) :
			((CW'(grid_h_q) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(grid_h_q));
		in_grid   = (CW'(row) < eff_h) && (CW'(col) < eff_w);
		accept    = in_valid && in_ready;
		item_addr = {SW'(row), SW'(col)};
		ia        = i_q[SW-1:0];
		ja        = j_q[SW-1:0];
		cell_addr = {ia, ja};
		cur_op    = rbps_pkg::op_desc(relax_q, op_q);
		last_op   = relax_q ? rbps_pkg::LAST_RELAX_OP : rbps_pkg::LAST_RESID_OP;
		step      = relax_q ? CW'(2) : CW'(1);
		jn        = j_q + step;
		cell_ok   = (j_q + CW'(1)) < eff_w;
		col_more  = (jn + CW'(1)) < eff_w;
		row_more  = (i_q + CW'(2)) < eff_h;
		// First column of the next row that has the current color.
		row_start = relax_q ? (CW'(1) + CW'(!(i_q[0] ^ color_q))) : CW'(1);
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			rbps_pkg::ST_CLEAR: begin
				if (&clr_q) begin
					st_d = rbps_pkg::ST_IDLE;
				end
			end
			rbps_pkg::ST_IDLE: begin
				if (accept) begin
					if (kind == rbps_pkg::KIND_RUN) begin
						st_d = rbps_pkg::ST_CELL;
					end else if (kind == rbps_pkg::KIND_READ && in_grid) begin
						st_d = rbps_pkg::ST_RDO;
					end
				end
			end
			rbps_pkg::ST_RDO: begin
				st_d = rbps_pkg::ST_IDLE;
			end
			rbps_pkg::ST_CELL: begin
				st_d = cell_ok ? rbps_pkg::ST_RD : rbps_pkg::ST_NEXT;
			end
			rbps_pkg::ST_RD: begin
				st_d = rbps_pkg::ST_MUL;
			end
			rbps_pkg::ST_MUL: begin
				st_d = rbps_pkg::ST_ACC;
			end
			rbps_pkg::ST_ACC: begin
				if (op_q != last_op) begin
					st_d = rbps_pkg::ST_RD;
				end else begin
					st_d = relax_q ? rbps_pkg::ST_SC0 : rbps_pkg::ST_WR;
				end
			end
			rbps_pkg::ST_SC0: begin
				st_d = rbps_pkg::ST_SC1;
			end
			rbps_pkg::ST_SC1: begin
				st_d = rbps_pkg::ST_SC2;
			end
			rbps_pkg::ST_SC2: begin
				st_d = rbps_pkg::ST_SC3;
			end
			rbps_pkg::ST_SC3: begin
				st_d = rbps_pkg::ST_SC4;
			end
			rbps_pkg::ST_SC4: begin
				st_d = rbps_pkg::ST_WR;
			end
			rbps_pkg::ST_WR: begin
				st_d = rbps_pkg::ST_NEXT;
			end
			rbps_pkg::ST_NEXT: begin
				if (col_more || row_more || relax_q) begin
					st_d = rbps_pkg::ST_CELL;
				end else begin
					st_d = rbps_pkg::ST_DONE;
				end
			end
			rbps_pkg::ST_DONE: begin
				st_d = rbps_pkg::ST_IDLE;
			end
			default: begin
				st_d = rbps_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: memory ports, multiplier request, handshake.
	always_comb begin
		in_ready  = (st_q == rbps_pkg::ST_IDLE) && (!out_valid_q || out_ready);
		phi_raddr = item_addr;
		phi_we    = 1'b0;
		phi_waddr = item_addr;
		phi_wdata = phi_value;
		rhs_we    = 1'b0;
		res_we    = 1'b0;
		res_waddr = cell_addr;
		res_wdata = rbps_pkg::sat32(final_val);
		mul_req.a  = phi_rd_q[31] ? (32'd0 - phi_rd_q) : phi_rd_q;
		mul_req.b  = cur_op.use_cy ? cy_q : cx_q;
		mul_req.sh = rbps_pkg::SH_16;
		case (st_q)
			rbps_pkg::ST_CLEAR: begin
				res_we    = 1'b1;
				res_waddr = clr_q;
				res_wdata = 32'd0;
			end
			rbps_pkg::ST_IDLE: begin
				phi_we = accept && (kind == rbps_pkg::KIND_WRITE) && in_grid;
				rhs_we = phi_we;
			end
			rbps_pkg::ST_SC1: begin
				mul_req.a  = 32'(nmag_q >> 32);
				mul_req.b  = den_q;
				mul_req.sh = rbps_pkg::SH_0;
			end
			rbps_pkg::ST_SC3: begin
				mul_req.a  = nmag_q[31:0];
				mul_req.b  = den_q;
				mul_req.sh = rbps_pkg::SH_32;
			end
			rbps_pkg::ST_WR: begin
				phi_we    = relax_q;
				phi_waddr = cell_addr;
				phi_wdata = rbps_pkg::sat32(final_val);
				res_we    = !relax_q;
			end
			default: begin
			end
		endcase
		// Neighbor address of the current operand during a run.
		if (st_q != rbps_pkg::ST_IDLE) begin
			case (cur_op.dir)
				rbps_pkg::DIR_E: begin
					phi_raddr = {ia, ja + SW'(1)};
				end
				rbps_pkg::DIR_W: begin
					phi_raddr = {ia, ja - SW'(1)};
				end
				rbps_pkg::DIR_N: begin
					phi_raddr = {ia + SW'(1), ja};
				end
				rbps_pkg::DIR_S: begin
					phi_raddr = {ia - SW'(1), ja};
				end
				default: begin
					phi_raddr = cell_addr;
				end
			endcase
		end
	end

	// Grid memories with registered reads.
	always_ff @(posedge clk) begin
		if (phi_we) begin
			phi_mem[phi_waddr] <= phi_wdata;
		end
		phi_rd_q <= phi_mem[phi_raddr];
	end

	always_ff @(posedge clk) begin
		if (rhs_we) begin
			rhs_mem[item_addr] <= rhs_value;
		end
		rhs_rd_q <= rhs_mem[cell_addr];
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_waddr] <= res_wdata;
		end
		res_rd_q <= res_mem[item_addr];
	end

	rbps_mul u_mul (
		.clk     (clk),
		.req     (mul_req),
		.prod_s1 (prod_s1)
	);

	// Term to accumulate and the signed result of a cell.
	always_comb begin
		term      = cur_op.dbl ? (ACC_W'(prod_s1) << 1) : ACC_W'(prod_s1);
		final_val = (relax_q && nneg_q) ? (ACC_W'(0) - acc_q) : acc_q;
	end

	// Accumulator and scaling operand.
	always_ff @(posedge clk) begin
		case (st_q)
			rbps_pkg::ST_MUL: begin
				sgn_q <= phi_rd_q[31];
				if (op_q == 3'd0) begin
					acc_q <= relax_q ?
						(ACC_W'(0) - {{(ACC_W-32){rhs_rd_q[31]}}, rhs_rd_q}) :
						{{(ACC_W-32){rhs_rd_q[31]}}, rhs_rd_q};
				end
			end
			rbps_pkg::ST_ACC: begin
				acc_q <= (sgn_q ^ cur_op.neg) ? (acc_q - term) : (acc_q + term);
			end
			rbps_pkg::ST_SC0: begin
				nneg_q <= acc_q[ACC_W-1];
				nmag_q <= acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
				acc_q  <= '0;
			end
			rbps_pkg::ST_SC2, rbps_pkg::ST_SC4: begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
			default: begin
			end
		endcase
	end

	// State register and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= rbps_pkg::ST_CLEAR;
			clr_q   <= '0;
			it_q    <= '0;
			color_q <= 1'b0;
			relax_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			op_q    <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				rbps_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				rbps_pkg::ST_IDLE: begin
					it_q    <= '0;
					color_q <= 1'b0;
					relax_q <= (sweep_q != 8'd0);
					i_q     <= CW'(1);
					j_q     <= (sweep_q != 8'd0) ? CW'(2) : CW'(1);
				end
				rbps_pkg::ST_CELL: begin
					op_q <= '0;
				end
				rbps_pkg::ST_ACC: begin
					op_q <= op_q + 3'd1;
				end
				rbps_pkg::ST_NEXT: begin
					if (col_more) begin
						j_q <= jn;
					end else if (row_more) begin
						i_q <= i_q + CW'(1);
						j_q <= row_start;
					end else if (relax_q) begin
						i_q <= CW'(1);
						if (!color_q) begin
							color_q <= 1'b1;
							j_q     <= CW'(1);
						end else if ((it_q + 8'd1) == sweep_q) begin
							relax_q <= 1'b0;
							color_q <= 1'b0;
							j_q     <= CW'(1);
						end else begin
							it_q    <= it_q + 8'd1;
							color_q <= 1'b0;
							j_q     <= CW'(2);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: loaded when an item finishes, emptied on a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == rbps_pkg::ST_IDLE && accept &&
				!(kind == rbps_pkg::KIND_RUN) &&
				!(kind == rbps_pkg::KIND_READ && in_grid)) ||
				st_q == rbps_pkg::ST_RDO || st_q == rbps_pkg::ST_DONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == rbps_pkg::ST_RDO) begin
			phi_out_q <= phi_rd_q;
			res_out_q <= res_rd_q;
			status_q  <= 1'b0;
		end else if (st_q == rbps_pkg::ST_DONE) begin
			phi_out_q <= 32'd0;
			res_out_q <= 32'd0;
			status_q  <= 1'b0;
		end else if (st_q == rbps_pkg::ST_IDLE && accept) begin
			phi_out_q <= 32'd0;
			res_out_q <= 32'd0;
			status_q  <= ((kind == rbps_pkg::KIND_WRITE) || (kind == rbps_pkg::KIND_READ))
				&& !in_grid;
		end
	end

	assign out_valid    = out_valid_q;
	assign phi_out      = phi_out_q;
	assign residual_out = res_out_q;
	assign status       = status_q;

	// A run blocks the input side once it is taken.
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == rbps_pkg::KIND_RUN) |=> !in_ready)
		else $error("input accepted right after a run item");

	// Relaxation and residual writes land on interior cells only.
	a_interior_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rbps_pkg::ST_WR) |->
		(i_q >= CW'(1) && (i_q + CW'(1)) < eff_h && j_q >= CW'(1) && (j_q + CW'(1)) < eff_w))
		else $error("cell update outside the interior");

	// The residual memory is written only by the clearing pass or a residual step.
	a_res_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_we |-> (st_q == rbps_pkg::ST_CLEAR || (st_q == rbps_pkg::ST_WR && !relax_q)))
		else $error("unexpected residual memory write");

	// No item is taken during the clearing pass.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rbps_pkg::ST_CLEAR) |-> !in_ready)
		else $error("input ready during clearing pass");

	// A result is produced only into an empty output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rbps_pkg::ST_DONE || st_q == rbps_pkg::ST_RDO) |-> !out_valid_q)
		else $error("result would overwrite a pending one");

endmodule

FILE: hw/rtl/rbps_mul.sv
// Shared registered 32x32 unsigned multiplier with a selectable right shift.
`timescale 1ns / 1ps

module rbps_mul (
	input  logic               clk,
	input  rbps_pkg::mul_req_t req,
	output logic [63:0]        prod_s1
);

	logic [63:0] full;
	logic [63:0] shifted;

	// Full product, then the truncating shift of the requested scaling.
	always_comb begin
		full = 64'(req.a) * 64'(req.b);
		case (req.sh)
			rbps_pkg::SH_0: begin
				shifted = full;
			end
			rbps_pkg::SH_16: begin
				shifted = full >> 16;
			end
			rbps_pkg::SH_32: begin
				shifted = full >> 32;
			end
			default: begin
				shifted = full;
			end
		endcase
	end

	// Product register.
	always_ff @(posedge clk) begin
		prod_s1 <= shifted;
	end

endmodule

FILE: test/red_black_poisson_smoother_checker.sv
// Checker that predicts and compares every result of the red-black Poisson smoother.
`timescale 1ns / 1ps

module red_black_poisson_smoother_checker (
	input  logic        clk,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	input  logic [31:0] phi_value,
	input  logic [31:0] rhs_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] phi_out,
	input  logic [31:0] residual_out,
	input  logic        status,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors
);

	localparam int SIDE = 64;

	typedef struct {
		logic [31:0] phi;
		logic [31:0] resid;
		logic        st;
	} cell_result_t;

	// Shadow copy of the grid and of the registers.
	int          pot_grid [SIDE*SIDE];
	int          src_grid [SIDE*SIDE];
	int          res_grid [SIDE*SIDE];
	logic [6:0]  width_reg;
	logic [6:0]  height_reg;
	logic [7:0]  sweeps_reg;
	int unsigned cx_reg;
	int unsigned cy_reg;
	int unsigned den_reg;

	cell_result_t pending_results[$];

	initial begin
		errors = 0;
		width_reg = rbps_pkg::RST_GRID_WIDTH;
		height_reg = rbps_pkg::RST_GRID_HEIGHT;
		sweeps_reg = rbps_pkg::RST_SWEEP_COUNT;
		cx_reg = rbps_pkg::RST_INV_DX2;
		cy_reg = rbps_pkg::RST_INV_DY2;
		den_reg = rbps_pkg::RST_INV_DEN;
		for (int k = 0; k < SIDE*SIDE; k++) begin
			pot_grid[k] = 0;
			src_grid[k] = 0;
			res_grid[k] = 0;
		end
	end

	function automatic int side_in_use(input logic [6:0] v);
		if (v < 3)
			return 3;
		if (v > SIDE)
			return SIDE;
		return v;
	endfunction

	// Q16.16 value times Q16.16 coefficient, truncated toward zero.
	function automatic longint scale_q16(input int a, input int unsigned c);
		longint unsigned mag;
		longint unsigned p;
		mag = (a < 0) ? longint'(-longint'(a)) : longint'(a);
		p = (mag * longint'(c)) >> 16;
		return (a < 0) ? -longint'(p) : longint'(p);
	endfunction

	// Wide value times Q0.32 fraction, truncated toward zero.
	function automatic longint scale_q32(input longint n, input int unsigned d);
		longint unsigned mag;
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned p;
		mag = (n < 0) ? longint'(-n) : longint'(n);
		hi = mag >> 32;
		lo = mag & 64'hFFFF_FFFF;
		p = hi * d + ((lo * d) >> 32);
		return (n < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic int clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return int'(v);
	endfunction

	// Red-black sweeps over the interior, then the residual of every interior cell.
	task automatic smooth_grid();
		int w;
		int h;
		int k;
		int p;
		longint acc;
		w = side_in_use(width_reg);
		h = side_in_use(height_reg);
		for (int it = 0; it < sweeps_reg; it++) begin
			for (int color = 0; color < 2; color++) begin
				for (int i = 1; i + 1 < h; i++) begin
					for (int j = 1 + ((i + color) & 1); j + 1 < w; j += 2) begin
						k = i * SIDE + j;
						acc = scale_q16(pot_grid[k+1], cx_reg) + scale_q16(pot_grid[k-1], cx_reg)
							+ scale_q16(pot_grid[k+SIDE], cy_reg)
							+ scale_q16(pot_grid[k-SIDE], cy_reg) - longint'(src_grid[k]);
						pot_grid[k] = clamp32(scale_q32(acc, den_reg));
					end
				end
			end
		end
		for (int i = 1; i + 1 < h; i++) begin
			for (int j = 1; j + 1 < w; j++) begin
				k = i * SIDE + j;
				p = pot_grid[k];
				acc = scale_q16(pot_grid[k+1], cx_reg) + scale_q16(pot_grid[k-1], cx_reg)
					- 2 * scale_q16(p, cx_reg)
					+ scale_q16(pot_grid[k+SIDE], cy_reg) + scale_q16(pot_grid[k-SIDE], cy_reg)
					- 2 * scale_q16(p, cy_reg);
				res_grid[k] = clamp32(longint'(src_grid[k]) - acc);
			end
		end
	endtask

	// Apply one accepted item to the shadow grid and return its result.
	task automatic predict_item(output cell_result_t r);
		logic in_grid;
		int   k;
		in_grid = (row < side_in_use(height_reg)) && (col < side_in_use(width_reg));
		k = row * SIDE + col;
		r.phi = '0;
		r.resid = '0;
		r.st = 1'b0;
		case (kind)
			rbps_pkg::KIND_WRITE: begin
				if (in_grid) begin
					pot_grid[k] = phi_value;
					src_grid[k] = rhs_value;
				end else begin
					r.st = 1'b1;
				end
			end
			rbps_pkg::KIND_RUN: begin
				smooth_grid();
			end
			rbps_pkg::KIND_READ: begin
				if (in_grid) begin
					r.phi = pot_grid[k];
					r.resid = res_grid[k];
				end else begin
					r.st = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Register writes, input transfers and output transfers, all sampled at the edge.
	always @(posedge clk) begin
		cell_result_t r;
		if (cfg_write) begin
			case (cfg_index)
				rbps_pkg::CFG_GRID_WIDTH: width_reg = cfg_data[6:0];
				rbps_pkg::CFG_GRID_HEIGHT: height_reg = cfg_data[6:0];
				rbps_pkg::CFG_SWEEP_COUNT: sweeps_reg = cfg_data[7:0];
				rbps_pkg::CFG_INV_DX2: cx_reg = cfg_data;
				rbps_pkg::CFG_INV_DY2: cy_reg = cfg_data;
				rbps_pkg::CFG_INV_DEN: den_reg = cfg_data;
				default: begin
				end
			endcase
		end
		if (in_valid && in_ready) begin
			predict_item(r);
			pending_results.push_back(r);
		end
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("result transfer with nothing expected");
			end else begin
				r = pending_results.pop_front();
				if (phi_out !== r.phi)
					report($sformatf("phi_out %h, expected %h", phi_out, r.phi));
				if (residual_out !== r.resid)
					report($sformatf("residual_out %h, expected %h", residual_out, r.resid));
				if (status !== r.st)
					report($sformatf("status %b, expected %b", status, r.st));
			end
		end
	end

endmodule

FILE: test/red_black_poisson_smoother_unit_tb.sv
// Top of the testbench for the red-black Poisson smoother: stimulus and verdict.
`timescale 1ns / 1ps

module red_black_poisson_smoother_unit_tb;

	// Kind value that the block ignores.
	localparam logic [1:0] KIND_IDLE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [5:0]  row;
	logic [5:0]  col;
	logic [31:0] phi_value;
	logic [31:0] rhs_value;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] phi_out;
	logic [31:0] residual_out;
	logic        status;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;

	int items_sent;
	int results_seen;
	bit gaps_on;
	bit grid_solved;
	int grid_w;
	int grid_h;

	red_black_poisson_smoother_unit dut (.*);

	red_black_poisson_smoother_checker u_checker (
		.clk(clk), .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .row(row),
		.col(col), .phi_value(phi_value), .rhs_value(rhs_value), .out_valid(out_valid),
		.out_ready(out_ready), .phi_out(phi_out), .residual_out(residual_out),
		.status(status), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .errors(errors)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold-off on the whole run.
	initial begin
		#200_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: a random stall before each result transfer while gaps are on.
	initial begin
		int stall;
		out_ready <= 1'b0;
		results_seen = 0;
		forever begin
			stall = gaps_on ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_seen++;
		end
	end

	function automatic int side_in_use(input int v);
		return (v < 3) ? 3 : ((v > 64) ? 64 : v);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return $urandom;
			default: return $urandom_range(0, 32'h7_ffff) - 32'h4_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_coeff();
		case ($urandom_range(0, 6))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: return $urandom_range(32'h4000, 32'h4_0000);
		endcase
	endfunction

	// One input transfer, after a random gap while gaps are on.
	task automatic send_item(input logic [1:0] k, input int r, input int c,
			input logic [31:0] p, input logic [31:0] s);
		int gap;
		gap = gaps_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		row <= 6'(r);
		col <= 6'(c);
		phi_value <= p;
		rhs_value <= s;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input int w, input int h, input int sw, input logic [31:0] cx,
			input logic [31:0] cy, input logic [31:0] den);
		logic [31:0] vals [6];
		vals = '{w, h, sw, cx, cy, den};
		wait_idle();
		for (int i = 0; i < 6; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		grid_w = side_in_use(w);
		grid_h = side_in_use(h);
	endtask

	// Load every cell of the grid in use so runs and reads only see written data.
	task automatic load_grid();
		for (int r = 0; r < grid_h; r++)
			for (int c = 0; c < grid_w; c++)
				send_item(rbps_pkg::KIND_WRITE, r, c, pick_value(), pick_value());
	endtask

	task automatic send_outside(input logic [1:0] k);
		int r;
		int c;
		if (grid_h < 64 && (grid_w == 64 || $urandom_range(0, 1))) begin
			r = $urandom_range(grid_h, 63);
			c = $urandom_range(0, 63);
		end else begin
			r = $urandom_range(0, 63);
			c = $urandom_range(grid_w, 63);
		end
		send_item(k, r, c, pick_value(), pick_value());
	endtask

	// Grid shape and coefficients for one phase; large sides only on thin grids.
	task automatic configure_phase();
		int w;
		int h;
		int sw;
		case ($urandom_range(0, 9))
			0: begin
				w = $urandom_range(0, 2);
				h = $urandom_range(0, 3);
				sw = $urandom_range(0, 1) ? 255 : $urandom_range(0, 255);
			end
			1: begin
				w = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
				h = $urandom_range(0, 4);
				sw = $urandom_range(0, 3);
			end
			2: begin
				h = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
				w = $urandom_range(0, 4);
				sw = $urandom_range(0, 3);
			end
			default: begin
				w = $urandom_range(3, 8);
				h = $urandom_range(3, 8);
				sw = $urandom_range(0, 4);
			end
		endcase
		if ($urandom_range(0, 2) == 0)
			write_regs(w, h, sw, rbps_pkg::RST_INV_DX2, rbps_pkg::RST_INV_DY2,
				rbps_pkg::RST_INV_DEN);
		else
			write_regs(w, h, sw, pick_coeff(), pick_coeff(),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h4000_0000));
	endtask

	task automatic random_phase();
		int n;
		int sel;
		n = $urandom_range(30, 50);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 19);
			if (sel < 6) begin
				send_item(rbps_pkg::KIND_WRITE, $urandom_range(0, grid_h - 1),
					$urandom_range(0, grid_w - 1), pick_value(), pick_value());
			end else if (sel < 8) begin
				send_outside(rbps_pkg::KIND_WRITE);
			end else if (sel < 14 && grid_solved) begin
				send_item(rbps_pkg::KIND_READ, $urandom_range(0, grid_h - 1),
					$urandom_range(0, grid_w - 1), pick_value(), pick_value());
			end else if (sel < 16) begin
				send_outside(rbps_pkg::KIND_READ);
			end else if (sel < 17) begin
				send_item(KIND_IDLE, $urandom_range(0, 63), $urandom_range(0, 63),
					pick_value(), pick_value());
			end else begin
				send_item(rbps_pkg::KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
					pick_value(), pick_value());
				grid_solved = 1'b1;
			end
		end
	endtask

	initial begin
		int t;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		kind <= rbps_pkg::KIND_WRITE;
		row <= '0;
		col <= '0;
		phi_value <= '0;
		rhs_value <= '0;
		cfg_write <= 1'b0;
		cfg_index <= rbps_pkg::CFG_GRID_WIDTH;
		cfg_data <= '0;
		items_sent = 0;
		gaps_on = 1'b1;
		grid_solved = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a 4 by 4 grid loaded with extreme values, then the special cases.
		write_regs(4, 4, 1, rbps_pkg::RST_INV_DX2, rbps_pkg::RST_INV_DY2,
			rbps_pkg::RST_INV_DEN);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				send_item(rbps_pkg::KIND_WRITE, r, c,
					((r + c) & 1) ? 32'h7fff_ffff : 32'h8000_0000,
					(r == c) ? 32'hffff_ffff : 32'h0001_0000);
		send_item(rbps_pkg::KIND_WRITE, 4, 0, 32'h1234_5678, 32'h0);
		send_item(KIND_IDLE, 63, 63, 32'hffff_ffff, 32'hffff_ffff);
		send_item(rbps_pkg::KIND_READ, 63, 63, 32'h0, 32'h0);
		send_item(rbps_pkg::KIND_RUN, 0, 0, 32'h0, 32'h0);
		grid_solved = 1'b1;
		send_item(rbps_pkg::KIND_READ, 1, 1, 32'h0, 32'h0);
		send_item(rbps_pkg::KIND_READ, 2, 2, 32'h0, 32'h0);
		send_item(rbps_pkg::KIND_READ, 0, 0, 32'h0, 32'h0);
		send_item(rbps_pkg::KIND_READ, 3, 3, 32'h0, 32'h0);

		// Random phases until about 1900 items have gone in.
		while (items_sent < 1900) begin
			configure_phase();
			gaps_on = ($urandom_range(0, 3) != 0);
			load_grid();
			random_phase();
		end

		// Drain, then the block's own latency.
		in_valid <= 1'b0;
		t = 0;
		while (results_seen != items_sent && t < 1_000_000) begin
			@(posedge clk);
			t++;
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && results_seen == items_sent && u_checker.pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
